// ===== hdl/dead_reckoning_pose_integrator_top_macros.svh =====
// Assertion macros for the pose integrator.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DEAD_RECKONING_POSE_INTEGRATOR_TOP_MACROS_SVH
`define DEAD_RECKONING_POSE_INTEGRATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRPI_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pose integrator check failed");

// The consequent must hold in the cycle after the antecedent.
`define DRPI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pose integrator check failed");

`endif

// ===== hdl/drpi_pkg.sv =====
`timescale 1ns / 1ps

package drpi_pkg;

  // Field widths of the transfer payloads.
  localparam int STAMP_W = 48;
  localparam int VEL_W   = 24;
  localparam int RATE_W  = 32;
  localparam int POS_W   = 32;
  localparam int ANG_W   = 32;

  // Sine and cosine are Q1.15.
  localparam int TRIG_W   = 16;
  localparam int FRAC_Q15 = 15;
  localparam int Q15_MAX  = 32767;

  // CORDIC datapath: Q2.30 with headroom.
  localparam int                   CW          = 34;
  localparam int                   CORDIC_MAX  = 24;
  localparam int                   ITER_W      = 5;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [ANG_W-1:0]     ANG_QUARTER = 32'h4000_0000;

  // Shared multiplier and accumulator.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 64;
  localparam int SPLIT   = 17;

  // Rotated velocity, Q26.8, and the bit positions of the rounded results.
  localparam int G_W      = 34;
  localparam int G_SH     = 7;
  localparam int POS_SH   = 28;
  localparam int HDG_SH   = 20;
  localparam int RND_G_SH = G_SH - 1;
  localparam int RND_P_SH = POS_SH - 1;
  localparam int RND_H_SH = HDG_SH - 1;

  // Program counter and the steps of the program.
  localparam int             PC_W      = 5;
  localparam logic [PC_W-1:0] S_IDLE    = 5'd0;
  localparam logic [PC_W-1:0] S_ROT     = 5'd1;
  localparam logic [PC_W-1:0] S_TRIG    = 5'd2;
  localparam logic [PC_W-1:0] S_GX_MUL  = 5'd3;
  localparam logic [PC_W-1:0] S_GX_LOAD = 5'd4;
  localparam logic [PC_W-1:0] S_GX_SUB  = 5'd5;
  localparam logic [PC_W-1:0] S_GX_RND  = 5'd6;
  localparam logic [PC_W-1:0] S_GX_WR   = 5'd7;
  localparam logic [PC_W-1:0] S_GY_ADD  = 5'd8;
  localparam logic [PC_W-1:0] S_GY_RND  = 5'd9;
  localparam logic [PC_W-1:0] S_GY_WR   = 5'd10;
  localparam logic [PC_W-1:0] S_PX_ADD  = 5'd11;
  localparam logic [PC_W-1:0] S_PX_RND  = 5'd12;
  localparam logic [PC_W-1:0] S_PX_WR   = 5'd13;
  localparam logic [PC_W-1:0] S_PY_ADD  = 5'd14;
  localparam logic [PC_W-1:0] S_PY_RND  = 5'd15;
  localparam logic [PC_W-1:0] S_PY_WR   = 5'd16;
  localparam logic [PC_W-1:0] S_HD_ADD  = 5'd17;
  localparam logic [PC_W-1:0] S_HD_RND  = 5'd18;
  localparam logic [PC_W-1:0] S_HD_WR   = 5'd19;
  localparam logic [PC_W-1:0] S_OUT     = 5'd20;

  // Payload of one input transfer.
  typedef struct packed {
    logic        [STAMP_W-1:0] stamp;
    logic signed [VEL_W-1:0]   vel_x;
    logic signed [VEL_W-1:0]   vel_y;
    logic signed [RATE_W-1:0]  yaw_rate;
  } in_item_t;

  // Payload of one output transfer.
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic        [ANG_W-1:0] heading;
  } out_item_t;

  // How the sequencer picks the next step.
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_WAIT_IN,
    JC_LOOP,
    JC_WAIT_OUT,
    JC_ALWAYS
  } jcond_e;

  typedef enum logic [1:0] {
    A_VX,
    A_VY,
    A_DT
  } asel_e;

  typedef enum logic [2:0] {
    B_COS,
    B_SIN,
    B_GX_LO,
    B_GX_HI,
    B_GY_LO,
    B_GY_HI,
    B_WR_LO,
    B_WR_HI
  } bsel_e;

  typedef enum logic [1:0] {
    AO_HOLD,
    AO_LOAD,
    AO_ADD,
    AO_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    AS_PROD,
    AS_PROD_HI,
    AS_RND
  } acc_src_e;

  typedef enum logic [1:0] {
    RND_G,
    RND_P,
    RND_H
  } rnd_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_GX,
    WR_GY,
    WR_PX,
    WR_PY,
    WR_HD
  } wsel_e;

  // One control word of the program.
  typedef struct packed {
    jcond_e          jc;
    logic [PC_W-1:0] target;
    logic            cordic_step;
    logic            trig_load;
    asel_e           a_sel;
    bsel_e           b_sel;
    acc_op_e         acc_op;
    acc_src_e        acc_src;
    rnd_e            rnd;
    wsel_e           wsel;
    logic            out_load;
  } ucw_t;

  // Status that steers the sequencer.
  typedef struct packed {
    logic in_fire;
    logic iter_last;
    logic out_free;
  } stat_t;

  localparam ucw_t UCW_NOP = '{
    jc: JC_NEXT, target: S_IDLE, cordic_step: 1'b0, trig_load: 1'b0,
    a_sel: A_VX, b_sel: B_COS, acc_op: AO_HOLD, acc_src: AS_PROD,
    rnd: RND_G, wsel: WR_NONE, out_load: 1'b0
  };

  // Arctangent of 2^-i in binary-angle units, 2^32 per turn.
  function automatic logic [ANG_W-1:0] cordic_atan(input logic [ITER_W-1:0] i);
    logic [ANG_W-1:0] a;
    case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // The program. A multiply issued in one step lands in the product
  // register for the accumulator in the next step.
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = UCW_NOP;
    case (pc)
      S_IDLE: begin
        w.jc = JC_WAIT_IN;
      end
      S_ROT: begin
        w.cordic_step = 1'b1;
        w.jc          = JC_LOOP;
        w.target      = S_ROT;
      end
      S_TRIG: begin
        w.trig_load = 1'b1;
      end
      S_GX_MUL: begin
        w.a_sel = A_VX;
        w.b_sel = B_COS;
      end
      S_GX_LOAD: begin
        w.a_sel  = A_VY;
        w.b_sel  = B_SIN;
        w.acc_op = AO_LOAD;
      end
      S_GX_SUB: begin
        w.a_sel  = A_VX;
        w.b_sel  = B_SIN;
        w.acc_op = AO_SUB;
      end
      S_GX_RND: begin
        w.a_sel   = A_VX;
        w.b_sel   = B_SIN;
        w.acc_op  = AO_ADD;
        w.acc_src = AS_RND;
        w.rnd     = RND_G;
      end
      S_GX_WR: begin
        w.wsel   = WR_GX;
        w.a_sel  = A_VY;
        w.b_sel  = B_COS;
        w.acc_op = AO_LOAD;
      end
      S_GY_ADD: begin
        w.a_sel  = A_DT;
        w.b_sel  = B_GX_LO;
        w.acc_op = AO_ADD;
      end
      S_GY_RND: begin
        w.a_sel   = A_DT;
        w.b_sel   = B_GX_LO;
        w.acc_op  = AO_ADD;
        w.acc_src = AS_RND;
        w.rnd     = RND_G;
      end
      S_GY_WR: begin
        w.wsel   = WR_GY;
        w.a_sel  = A_DT;
        w.b_sel  = B_GX_HI;
        w.acc_op = AO_LOAD;
      end
      S_PX_ADD: begin
        w.a_sel   = A_DT;
        w.b_sel   = B_GY_LO;
        w.acc_op  = AO_ADD;
        w.acc_src = AS_PROD_HI;
      end
      S_PX_RND: begin
        w.a_sel   = A_DT;
        w.b_sel   = B_GY_LO;
        w.acc_op  = AO_ADD;
        w.acc_src = AS_RND;
        w.rnd     = RND_P;
      end
      S_PX_WR: begin
        w.wsel   = WR_PX;
        w.a_sel  = A_DT;
        w.b_sel  = B_GY_HI;
        w.acc_op = AO_LOAD;
      end
      S_PY_ADD: begin
        w.a_sel   = A_DT;
        w.b_sel   = B_WR_LO;
        w.acc_op  = AO_ADD;
        w.acc_src = AS_PROD_HI;
      end
      S_PY_RND: begin
        w.a_sel   = A_DT;
        w.b_sel   = B_WR_LO;
        w.acc_op  = AO_ADD;
        w.acc_src = AS_RND;
        w.rnd     = RND_P;
      end
      S_PY_WR: begin
        w.wsel   = WR_PY;
        w.a_sel  = A_DT;
        w.b_sel  = B_WR_HI;
        w.acc_op = AO_LOAD;
      end
      S_HD_ADD: begin
        w.acc_op  = AO_ADD;
        w.acc_src = AS_PROD_HI;
      end
      S_HD_RND: begin
        w.acc_op  = AO_ADD;
        w.acc_src = AS_RND;
        w.rnd     = RND_H;
      end
      S_HD_WR: begin
        w.wsel = WR_HD;
      end
      S_OUT: begin
        w.out_load = 1'b1;
        w.jc       = JC_WAIT_OUT;
        w.target   = S_IDLE;
      end
      default: begin
        w.jc     = JC_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/drpi_sequencer.sv =====
`timescale 1ns / 1ps

module drpi_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  drpi_pkg::stat_t stat_i,
  output drpi_pkg::ucw_t  ctrl_o
);

  logic [drpi_pkg::PC_W-1:0] pc_q;
  logic [drpi_pkg::PC_W-1:0] pc_d;
  logic [drpi_pkg::PC_W-1:0] pc_inc;

  // Fetch the control word of the current step.
  assign ctrl_o = drpi_pkg::ucode(pc_q);
  assign pc_inc = pc_q + drpi_pkg::PC_W'(1);

  // Next step from the jump condition of the current word.
  always_comb begin
    case (ctrl_o.jc)
      drpi_pkg::JC_NEXT:     pc_d = pc_inc;
      drpi_pkg::JC_WAIT_IN:  pc_d = stat_i.in_fire ? pc_inc : pc_q;
      drpi_pkg::JC_LOOP:     pc_d = stat_i.iter_last ? pc_inc : ctrl_o.target;
      drpi_pkg::JC_WAIT_OUT: pc_d = stat_i.out_free ? ctrl_o.target : pc_q;
      drpi_pkg::JC_ALWAYS:   pc_d = ctrl_o.target;
      default:               pc_d = drpi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= drpi_pkg::S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== hdl/drpi_cordic.sv =====
`timescale 1ns / 1ps

module drpi_cordic #(
  parameter int TRIG_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [drpi_pkg::ANG_W-1:0]             heading_i,
  input  logic                                   step_i,
  input  logic                                   load_i,
  output logic                                   iter_last_o,
  output logic signed [drpi_pkg::TRIG_W-1:0]     cos_o,
  output logic signed [drpi_pkg::TRIG_W-1:0]     sin_o
);

  localparam int CW = drpi_pkg::CW;
  localparam int RW = CW - drpi_pkg::FRAC_Q15 + 1;
  localparam int QW = drpi_pkg::TRIG_W;
  localparam logic [drpi_pkg::ITER_W-1:0] LAST_ITER = drpi_pkg::ITER_W'(TRIG_BITS - 1);
  localparam logic signed [RW-1:0] R_MAX = RW'(drpi_pkg::Q15_MAX);
  localparam logic signed [RW-1:0] R_MIN = -R_MAX;
  localparam logic signed [CW:0]   Q15_HALF = (CW + 1)'(1) <<< (drpi_pkg::FRAC_Q15 - 1);

  logic signed [CW-1:0]            x_q, y_q, z_q;
  logic signed [CW-1:0]            x_d, y_d, z_d;
  logic signed [CW-1:0]            x_sh, y_sh, atan_v;
  logic signed [CW-1:0]            z_start, x_fin, y_fin;
  logic [drpi_pkg::ANG_W-1:0]      quarter, b_ang;
  logic                            flip_d, flip_q;
  logic [drpi_pkg::ITER_W-1:0]     iter_q;
  logic signed [QW-1:0]            cos_q, sin_q;

  // Round Q2.30 to Q1.15 (add half, floor) and clamp to the symmetric range.
  function automatic logic signed [QW-1:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW:0]   sum;
    logic signed [RW-1:0] r;
    sum = (CW + 1)'(v) + Q15_HALF;
    r   = sum[CW:drpi_pkg::FRAC_Q15];
    if (r > R_MAX) begin
      return R_MAX[QW-1:0];
    end else if (r < R_MIN) begin
      return R_MIN[QW-1:0];
    end
    return r[QW-1:0];
  endfunction

  // Fold the left half plane by half a turn; the results are negated later.
  always_comb begin
    quarter = heading_i + drpi_pkg::ANG_QUARTER;
    flip_d  = quarter[drpi_pkg::ANG_W-1];
    b_ang   = heading_i ^ {flip_d, {(drpi_pkg::ANG_W-1){1'b0}}};
    z_start = CW'($signed(b_ang));
  end

  // One micro-rotation per step, direction from the sign of the residual angle.
  always_comb begin
    x_sh   = x_q >>> iter_q;
    y_sh   = y_q >>> iter_q;
    atan_v = CW'(drpi_pkg::cordic_atan(iter_q));
    if (!z_q[CW-1]) begin
      x_d = x_q - y_sh;
      y_d = y_q + x_sh;
      z_d = z_q - atan_v;
    end else begin
      x_d = x_q + y_sh;
      y_d = y_q - x_sh;
      z_d = z_q + atan_v;
    end
  end

  assign x_fin = flip_q ? -x_q : x_q;
  assign y_fin = flip_q ? -y_q : y_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= drpi_pkg::CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= z_start;
      flip_q <= flip_d;
    end else if (step_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
    if (load_i) begin
      cos_q <= to_q15(x_fin);
      sin_q <= to_q15(y_fin);
    end
  end

  // Iteration counter; it also indexes the arctangent table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (start_i) begin
      iter_q <= '0;
    end else if (step_i) begin
      iter_q <= iter_q + drpi_pkg::ITER_W'(1);
    end
  end

  assign iter_last_o = (iter_q == LAST_ITER);
  assign cos_o       = cos_q;
  assign sin_o       = sin_q;

endmodule

// ===== hdl/drpi_datapath.sv =====
`timescale 1ns / 1ps

module drpi_datapath #(
  parameter int DELTA_LIMIT_BITS = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  drpi_pkg::ucw_t                     ctrl_i,
  input  logic                               in_fire_i,
  input  drpi_pkg::in_item_t                 in_data_i,
  input  logic signed [drpi_pkg::TRIG_W-1:0] cos_i,
  input  logic signed [drpi_pkg::TRIG_W-1:0] sin_i,
  output drpi_pkg::out_item_t                pose_o
);

  localparam int DT_W  = DELTA_LIMIT_BITS + 2;
  localparam int SW    = drpi_pkg::STAMP_W;
  localparam int AW    = drpi_pkg::MUL_A_W;
  localparam int BW    = drpi_pkg::MUL_B_W;
  localparam int PW    = drpi_pkg::PROD_W;
  localparam int ACW   = drpi_pkg::ACC_W;
  localparam int GW    = drpi_pkg::G_W;
  localparam int SPL   = drpi_pkg::SPLIT;
  localparam int RTW   = drpi_pkg::RATE_W;
  localparam int POSW  = drpi_pkg::POS_W;
  localparam int ANGW  = drpi_pkg::ANG_W;

  localparam logic signed [SW:0] LIM_POS =
    {{(SW - DELTA_LIMIT_BITS){1'b0}}, 1'b1, {DELTA_LIMIT_BITS{1'b0}}};
  localparam logic signed [SW:0]     LIM_NEG = -LIM_POS;
  localparam logic signed [DT_W-1:0] DT_MAX  = {2'b01, {DELTA_LIMIT_BITS{1'b0}}};
  localparam logic signed [DT_W-1:0] DT_MIN  = {2'b11, {DELTA_LIMIT_BITS{1'b0}}};

  logic [SW-1:0]                   last_stamp_q;
  logic                            seen_q;
  logic signed [SW:0]              diff;
  logic signed [DT_W-1:0]          dt_d, dt_q;
  logic signed [drpi_pkg::VEL_W-1:0] vx_q, vy_q;
  logic signed [RTW-1:0]           wr_q;
  logic signed [AW-1:0]            mul_a;
  logic signed [BW-1:0]            mul_b;
  logic signed [PW-1:0]            prod_d, prod_q;
  logic [ACW-1:0]                  addend, acc_d, acc_q;
  logic [GW-1:0]                   gx_q, gy_q;
  logic [POSW-1:0]                 pos_x_q, pos_y_q;
  logic [ANGW-1:0]                 heading_q;

  // Time since the previous item, saturated; zero until a stamp was seen.
  always_comb begin
    diff = $signed({1'b0, in_data_i.stamp}) - $signed({1'b0, last_stamp_q});
    if (!seen_q) begin
      dt_d = '0;
    end else if (diff > LIM_POS) begin
      dt_d = DT_MAX;
    end else if (diff < LIM_NEG) begin
      dt_d = DT_MIN;
    end else begin
      dt_d = diff[DT_W-1:0];
    end
  end

  // Operand selection for the shared multiplier. Wide operands are split
  // into an unsigned low part and a signed high part.
  always_comb begin
    case (ctrl_i.a_sel)
      drpi_pkg::A_VX: mul_a = AW'(vx_q);
      drpi_pkg::A_VY: mul_a = AW'(vy_q);
      drpi_pkg::A_DT: mul_a = AW'(dt_q);
      default:        mul_a = '0;
    endcase
    case (ctrl_i.b_sel)
      drpi_pkg::B_COS:   mul_b = BW'(cos_i);
      drpi_pkg::B_SIN:   mul_b = BW'(sin_i);
      drpi_pkg::B_GX_LO: mul_b = {1'b0, gx_q[SPL-1:0]};
      drpi_pkg::B_GX_HI: mul_b = BW'($signed(gx_q[GW-1:SPL]));
      drpi_pkg::B_GY_LO: mul_b = {1'b0, gy_q[SPL-1:0]};
      drpi_pkg::B_GY_HI: mul_b = BW'($signed(gy_q[GW-1:SPL]));
      drpi_pkg::B_WR_LO: mul_b = {1'b0, wr_q[SPL-1:0]};
      drpi_pkg::B_WR_HI: mul_b = BW'($signed(wr_q[RTW-1:SPL]));
      default:           mul_b = '0;
    endcase
    prod_d = mul_a * mul_b;
  end

  // Accumulator addend: product, product weighted by the split, or a
  // rounding half.
  always_comb begin
    case (ctrl_i.acc_src)
      drpi_pkg::AS_PROD:    addend = ACW'(prod_q);
      drpi_pkg::AS_PROD_HI: addend = ACW'(prod_q) << SPL;
      drpi_pkg::AS_RND: begin
        case (ctrl_i.rnd)
          drpi_pkg::RND_G: addend = ACW'(1) << drpi_pkg::RND_G_SH;
          drpi_pkg::RND_P: addend = ACW'(1) << drpi_pkg::RND_P_SH;
          drpi_pkg::RND_H: addend = ACW'(1) << drpi_pkg::RND_H_SH;
          default:         addend = '0;
        endcase
      end
      default: addend = '0;
    endcase
    case (ctrl_i.acc_op)
      drpi_pkg::AO_LOAD: acc_d = addend;
      drpi_pkg::AO_ADD:  acc_d = acc_q + addend;
      drpi_pkg::AO_SUB:  acc_d = acc_q - addend;
      default:           acc_d = acc_q;
    endcase
  end

  // Captured item, product and accumulator, and the rotated velocity.
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      vx_q <= in_data_i.vel_x;
      vy_q <= in_data_i.vel_y;
      wr_q <= in_data_i.yaw_rate;
      dt_q <= dt_d;
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (ctrl_i.wsel == drpi_pkg::WR_GX) begin
      gx_q <= acc_q[drpi_pkg::G_SH+GW-1:drpi_pkg::G_SH];
    end
    if (ctrl_i.wsel == drpi_pkg::WR_GY) begin
      gy_q <= acc_q[drpi_pkg::G_SH+GW-1:drpi_pkg::G_SH];
    end
  end

  // Integrated pose and time base.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_stamp_q <= '0;
      seen_q       <= 1'b0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      heading_q    <= '0;
    end else begin
      if (in_fire_i) begin
        last_stamp_q <= in_data_i.stamp;
        seen_q       <= 1'b1;
      end
      case (ctrl_i.wsel)
        drpi_pkg::WR_PX:
          pos_x_q <= pos_x_q + acc_q[drpi_pkg::POS_SH+POSW-1:drpi_pkg::POS_SH];
        drpi_pkg::WR_PY:
          pos_y_q <= pos_y_q + acc_q[drpi_pkg::POS_SH+POSW-1:drpi_pkg::POS_SH];
        drpi_pkg::WR_HD:
          heading_q <= heading_q + acc_q[drpi_pkg::HDG_SH+ANGW-1:drpi_pkg::HDG_SH];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pose_o.pos_x   = pos_x_q;
    pose_o.pos_y   = pos_y_q;
    pose_o.heading = heading_q;
  end

endmodule

// ===== hdl/dead_reckoning_pose_integrator_top.sv =====
// Planar odometry pose integrator. Each input transfer carries a timestamp,
// a body-frame velocity and a yaw rate; the block rotates the velocity by
// the stored heading (CORDIC sine and cosine, TRIG_BITS iterations),
// integrates x, y and heading over the time since the previous item
// (saturated to plus or minus 2^DELTA_LIMIT_BITS ticks, zero for the first
// item after reset) and emits the updated pose as one output transfer. A
// small microcoded sequencer drives one CORDIC unit and one shared 32x18
// multiplier with a 64-bit accumulator. The time one item takes is set by
// the CORDIC loop and the ten products that go through the shared
// multiplier one after another; a new item is taken only once the
// previous one is through. The output register holds a finished pose
// while the next item is already taken in.
`timescale 1ns / 1ps
`include "dead_reckoning_pose_integrator_top_macros.svh"

module dead_reckoning_pose_integrator_top #(
  parameter int TRIG_BITS        = 16,
  parameter int DELTA_LIMIT_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  drpi_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output drpi_pkg::out_item_t out_data_o
);

  drpi_pkg::ucw_t                     ctrl;
  drpi_pkg::stat_t                    stat;
  drpi_pkg::out_item_t                pose;
  drpi_pkg::out_item_t                out_q;
  logic                               out_valid_q;
  logic                               out_valid_d;
  logic                               in_fire;
  logic                               out_free;
  logic                               out_fire_load;
  logic                               iter_last;
  logic signed [drpi_pkg::TRIG_W-1:0] cos_v;
  logic signed [drpi_pkg::TRIG_W-1:0] sin_v;

  // Input handshake: items are taken only in the idle step.
  assign in_ready_o    = (ctrl.jc == drpi_pkg::JC_WAIT_IN);
  assign in_fire       = in_valid_i & in_ready_o;
  assign out_free      = ~out_valid_q | out_ready_i;
  assign out_fire_load = ctrl.out_load & out_free;

  always_comb begin
    stat.in_fire   = in_fire;
    stat.iter_last = iter_last;
    stat.out_free  = out_free;
  end

  drpi_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  drpi_cordic #(
    .TRIG_BITS (TRIG_BITS)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_fire),
    .heading_i   (pose.heading),
    .step_i      (ctrl.cordic_step),
    .load_i      (ctrl.trig_load),
    .iter_last_o (iter_last),
    .cos_o       (cos_v),
    .sin_o       (sin_v)
  );

  drpi_datapath #(
    .DELTA_LIMIT_BITS (DELTA_LIMIT_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .in_fire_i (in_fire),
    .in_data_i (in_data_i),
    .cos_i     (cos_v),
    .sin_i     (sin_v),
    .pose_o    (pose)
  );

  // Output register: loaded when the final step finds it free.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_fire_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire_load) begin
      out_q <= pose;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Once an item is taken the sequencer leaves the idle step.
  `DRPI_ASSERT_NEXT(a_busy_after_take, in_fire, !in_ready_o)
  // A new result only appears after the final step of the program.
  `DRPI_ASSERT_SAME(a_result_from_final, $rose(out_valid_q), $past(ctrl.jc == drpi_pkg::JC_WAIT_OUT))
  // After a result is loaded the block is ready for the next item.
  `DRPI_ASSERT_NEXT(a_idle_after_result, out_fire_load, in_ready_o)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int TRIG_ITERS    = 16;
  localparam int DT_LIMIT_BITS = 20;
  localparam int LATENCY       = TRIG_ITERS + 20;
  localparam int QUIET_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 400;

  localparam longint DT_LIMIT = longint'(1) << DT_LIMIT_BITS;
  localparam longint GAIN_Q30 = 652032874;
  localparam longint ATAN_TURNS [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // One second in stamp ticks; a yaw rate held this long turns by itself.
  localparam logic [drpi_pkg::STAMP_W-1:0] ONE_SECOND = 48'd1048576;
  localparam logic [drpi_pkg::STAMP_W-1:0] STAMP_HALF = 48'h8000_0000_0000;

  localparam logic signed [drpi_pkg::VEL_W-1:0] VEL_MAX =
    {1'b0, {(drpi_pkg::VEL_W-1){1'b1}}};
  localparam logic signed [drpi_pkg::VEL_W-1:0] VEL_MIN =
    {1'b1, {(drpi_pkg::VEL_W-1){1'b0}}};
  localparam logic [drpi_pkg::RATE_W-1:0] YAW_MAX = {1'b0, {(drpi_pkg::RATE_W-1){1'b1}}};
  localparam logic [drpi_pkg::RATE_W-1:0] YAW_MIN = {1'b1, {(drpi_pkg::RATE_W-1){1'b0}}};

  // Pose predictor and the queue of poses still owed by the block.
  class pose_scoreboard;
    logic [drpi_pkg::STAMP_W-1:0] last_stamp;
    bit                           stamp_seen;
    logic [drpi_pkg::POS_W-1:0]   acc_x;
    logic [drpi_pkg::POS_W-1:0]   acc_y;
    logic [drpi_pkg::ANG_W-1:0]   acc_hdg;
    drpi_pkg::out_item_t          pose_q[$];
    int                           errors;

    function new();
      last_stamp = '0;
      stamp_seen = 1'b0;
      acc_x      = '0;
      acc_y      = '0;
      acc_hdg    = '0;
      errors     = 0;
    endfunction

    function longint round_q15(longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > drpi_pkg::Q15_MAX) r = drpi_pkg::Q15_MAX;
      if (r < -drpi_pkg::Q15_MAX) r = -drpi_pkg::Q15_MAX;
      return r;
    endfunction

    // CORDIC rotation; the left half plane is folded over by half a turn.
    function void sin_cos(input logic [drpi_pkg::ANG_W-1:0] ang, output longint c,
                          output longint s);
      logic [drpi_pkg::ANG_W-1:0] turned;
      logic [drpi_pkg::ANG_W-1:0] b;
      bit                         flip;
      longint                     x;
      longint                     y;
      longint                     z;
      longint                     t;
      turned = ang + drpi_pkg::ANG_QUARTER;
      b      = ang;
      flip   = 1'b0;
      if (turned[drpi_pkg::ANG_W-1]) begin
        b    = ang + 32'h8000_0000;
        flip = 1'b1;
      end
      z = longint'($signed(b));
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < TRIG_ITERS && i < 24; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= ATAN_TURNS[i];
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += ATAN_TURNS[i];
        end
        x = t;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = round_q15(x);
      s = round_q15(y);
    endfunction

    // Integrate one accepted odometry transfer and queue the pose it yields.
    function void log_odometry(drpi_pkg::in_item_t it);
      longint              dt;
      longint              c;
      longint              s;
      longint              vx;
      longint              vy;
      longint              wr;
      longint              gx;
      longint              gy;
      longint              dx;
      longint              dy;
      longint              dh;
      drpi_pkg::out_item_t pose;
      dt = 0;
      if (stamp_seen) begin
        dt = longint'({16'd0, it.stamp}) - longint'({16'd0, last_stamp});
        if (dt > DT_LIMIT) dt = DT_LIMIT;
        if (dt < -DT_LIMIT) dt = -DT_LIMIT;
      end
      last_stamp = it.stamp;
      stamp_seen = 1'b1;

      sin_cos(acc_hdg, c, s);
      vx = $signed(it.vel_x);
      vy = $signed(it.vel_y);
      wr = $signed(it.yaw_rate);
      gx = (vx * c - vy * s + 64) >>> 7;
      gy = (vx * s + vy * c + 64) >>> 7;
      dx = (gx * dt + (longint'(1) << 27)) >>> 28;
      dy = (gy * dt + (longint'(1) << 27)) >>> 28;
      dh = (wr * dt + (longint'(1) << 19)) >>> 20;

      acc_x   = acc_x + 32'(dx);
      acc_y   = acc_y + 32'(dy);
      acc_hdg = acc_hdg + 32'(dh);

      pose.pos_x   = acc_x;
      pose.pos_y   = acc_y;
      pose.heading = acc_hdg;
      pose_q = {pose_q, pose};
    endfunction

    // Compare one pose transfer with the oldest owed pose.
    function void check_pose(drpi_pkg::out_item_t got);
      drpi_pkg::out_item_t want;
      if (pose_q.size() == 0) begin
        errors++;
        $display("%0t unexpected pose: x=%0d y=%0d heading=%0d", $time,
                 got.pos_x, got.pos_y, got.heading);
        return;
      end
      want = pose_q.pop_front();
      if (got.pos_x !== want.pos_x) begin
        errors++;
        $display("%0t pos_x mismatch: expected %0d, actual %0d", $time,
                 want.pos_x, got.pos_x);
      end
      if (got.pos_y !== want.pos_y) begin
        errors++;
        $display("%0t pos_y mismatch: expected %0d, actual %0d", $time,
                 want.pos_y, got.pos_y);
      end
      if (got.heading !== want.heading) begin
        errors++;
        $display("%0t heading mismatch: expected %0d, actual %0d", $time,
                 want.heading, got.heading);
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  drpi_pkg::in_item_t  in_data_i   = '0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  drpi_pkg::out_item_t out_data_o;

  pose_scoreboard sb = new();

  int                           tx_idle_pct = 0;
  int                           rx_idle_pct = 0;
  bit                           hold_req    = 1'b0;
  logic [drpi_pkg::STAMP_W-1:0] stamp_now   = '0;

  dead_reckoning_pose_integrator_top #(
    .TRIG_BITS       (TRIG_ITERS),
    .DELTA_LIMIT_BITS(DT_LIMIT_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Both channels are sampled at the edge where a transfer takes place.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.log_odometry(in_data_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_pose(out_data_o);
    end
  end

  // Pose receiver: random back-pressure, plus one long hold when asked.
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // The run is stuck if no transfer happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one odometry sample and hold it until the transfer.
  task automatic offer(input logic [drpi_pkg::STAMP_W-1:0] st,
                       input logic signed [drpi_pkg::VEL_W-1:0] vx,
                       input logic signed [drpi_pkg::VEL_W-1:0] vy,
                       input logic [drpi_pkg::RATE_W-1:0] yaw);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{stamp: st, vel_x: vx, vel_y: vy, yaw_rate: yaw};
    stamp_now = st;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending until every owed pose has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pose_q.size() != 0);
  endtask

  // Send one sample lasting exactly one second that brings the heading to target.
  task automatic steer_to(input logic [drpi_pkg::ANG_W-1:0] target,
                          input logic signed [drpi_pkg::VEL_W-1:0] vx,
                          input logic signed [drpi_pkg::VEL_W-1:0] vy);
    logic [drpi_pkg::ANG_W-1:0]   turn;
    logic [drpi_pkg::STAMP_W-1:0] st;
    wait_drained();
    turn = target - sb.acc_hdg;
    if (stamp_now >= STAMP_HALF) begin
      // Going back in time reverses the turn, so the rate is negated.
      st   = stamp_now - ONE_SECOND;
      turn = -turn;
    end else begin
      st = stamp_now + ONE_SECOND;
    end
    offer(st, vx, vy, turn);
  endtask

  // Mostly steady sampling, with backward stamps and wild jumps mixed in.
  task automatic run_mixed(input int n);
    int                                kind;
    logic [drpi_pkg::STAMP_W-1:0]      st;
    logic signed [drpi_pkg::VEL_W-1:0] vx;
    logic signed [drpi_pkg::VEL_W-1:0] vy;
    logic [drpi_pkg::RATE_W-1:0]       yaw;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        case ($urandom_range(2))
          0:       st = stamp_now + $urandom_range(0, 1 << 16);
          1:       st = stamp_now + $urandom_range(1 << 16, 1 << 21);
          default: st = stamp_now + $urandom_range(0, 1 << 23);
        endcase
      end else if (kind < 85) begin
        st = stamp_now - $urandom_range(0, 1 << 22);
      end else begin
        st = 48'({$urandom, $urandom});
      end
      if ($urandom_range(9) == 0) vx = $urandom_range(1) ? VEL_MAX : VEL_MIN;
      else vx = 24'($urandom);
      if ($urandom_range(9) == 0) vy = $urandom_range(1) ? VEL_MAX : VEL_MIN;
      else vy = 24'($urandom);
      if ($urandom_range(9) == 0) yaw = $urandom_range(1) ? YAW_MAX : YAW_MIN;
      else yaw = $urandom;
      offer(st, vx, vy, yaw);
    end
  endtask

  // Straight run at top speed with saturated steps, heading away from zero
  // on both axes so that each position register wraps.
  task automatic run_cruise(input int n);
    bit                           back;
    bit                           neg_x;
    bit                           neg_y;
    int                           mx;
    int                           my;
    logic [drpi_pkg::STAMP_W-1:0] adv;
    logic [drpi_pkg::STAMP_W-1:0] st;
    wait_drained();
    back  = (stamp_now >= STAMP_HALF);
    neg_x = ((sb.acc_x[drpi_pkg::POS_W-1] == 1'b0) == back);
    neg_y = ((sb.acc_y[drpi_pkg::POS_W-1] == 1'b0) == back);
    for (int i = 0; i < n; i++) begin
      adv = 48'($urandom_range(1 << 20, 1 << 24));
      st  = back ? stamp_now - adv : stamp_now + adv;
      mx  = 8388607 - $urandom_range(4095);
      my  = 8388607 - $urandom_range(4095);
      offer(st, 24'(neg_x ? -mx : mx), 24'(neg_y ? -my : my), '0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first sample, saturation edges, stamp extremes.
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    offer(48'h0123_4567_89AB, VEL_MAX, VEL_MIN, YAW_MAX);
    offer(stamp_now + ONE_SECOND, VEL_MAX, VEL_MAX, 32'h2000_0000);
    offer(stamp_now + 1, VEL_MIN, VEL_MAX, YAW_MIN);
    offer(stamp_now, '0, '0, YAW_MAX);
    offer(stamp_now + ONE_SECOND + 1, VEL_MAX, VEL_MIN, YAW_MIN);
    offer(stamp_now - ONE_SECOND, '1, 24'sd1, '1);
    offer(stamp_now - ONE_SECOND - 1, VEL_MIN, VEL_MIN, YAW_MAX);
    offer('0, VEL_MAX, VEL_MAX, YAW_MAX);
    offer('1, VEL_MIN, VEL_MIN, YAW_MIN);
    offer(stamp_now - 5000, 24'($urandom), 24'($urandom), $urandom);

    // Headings on both sides of each quadrant boundary of the CORDIC fold.
    steer_to(32'h3FFF_FFFF, VEL_MAX, VEL_MAX);
    steer_to(32'h4000_0000, VEL_MIN, VEL_MAX);
    steer_to(32'h8000_0000, VEL_MAX, VEL_MIN);
    steer_to(32'hBFFF_FFFF, VEL_MIN, VEL_MIN);
    steer_to(32'hC000_0000, VEL_MAX, VEL_MAX);
    steer_to(32'hFFFF_FFFF, VEL_MIN, VEL_MAX);
    steer_to(32'h0000_0000, VEL_MAX, VEL_MIN);

    // Slow receiver, with one long hold so the block backs up.
    wait_drained();
    tx_idle_pct = 7;
    rx_idle_pct = 87;
    hold_req    = 1'b1;
    run_mixed(145);

    // Slow sender.
    wait_drained();
    tx_idle_pct = 87;
    rx_idle_pct = 7;
    run_mixed(145);

    // Full rate: face along the x axis and drive until both positions wrap.
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    steer_to(32'h0000_0000, VEL_MAX, VEL_MIN);
    run_cruise(264);

    wait_drained();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (sb.errors == 0 && sb.pose_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
